### hdl/dwso_pkg.sv
package dwso_pkg;

  // Window lengths
  localparam int TOTAL_LEN = 128;
  localparam int SHORT_LEN = 16;
  localparam int LONG_LEN  = TOTAL_LEN - SHORT_LEN;

  // Field widths
  localparam int SAMPLE_W = 14;
  localparam int LIGHT_W  = 17;

  // Running sum widths, sized for a full window of maximum samples
  localparam int SAMPLE_MAX = (2 ** SAMPLE_W) - 1;
  localparam int RECENT_W   = $clog2(SHORT_LEN * SAMPLE_MAX + 1);
  localparam int OLDER_W    = $clog2(LONG_LEN * SAMPLE_MAX + 1);

  // Ratio test 200*recent*LONG_LEN > 201*older*SHORT_LEN
  localparam int LHS_K   = 200 * LONG_LEN;
  localparam int RHS_K   = 201 * SHORT_LEN;
  localparam int LHS_W   = RECENT_W + $clog2(LHS_K + 1);
  localparam int RHS_W   = OLDER_W + $clog2(RHS_K + 1);
  localparam int PROD_W  = (LHS_W > RHS_W) ? LHS_W : RHS_W;

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [LIGHT_W-1:0]  light_t;
  typedef logic [RECENT_W-1:0] recent_t;
  typedef logic [OLDER_W-1:0]  older_t;
  typedef logic [PROD_W-1:0]   prod_t;

  // Window sums handed from the window to the decision logic
  typedef struct packed {
    recent_t recent;
    older_t  older;
  } win_sums_t;

endpackage

### hdl/dwso_ifs.sv
interface dwso_in_if
  import dwso_pkg::*;
();
  logic    valid;
  logic    ready;
  sample_t sample;
  light_t  light_level;

  modport source (output valid, output sample, output light_level, input ready);
  modport sink   (input valid, input sample, input light_level, output ready);
endinterface

interface dwso_out_if;
  logic valid;
  logic ready;
  logic onset;

  modport source (output valid, output onset, input ready);
  modport sink   (input valid, input onset, output ready);
endinterface

interface dwso_cfg_if
  import dwso_pkg::*;
();
  logic   valid;
  logic   ready;
  light_t light_threshold;

  modport source (output valid, output light_threshold, input ready);
  modport sink   (input valid, input light_threshold, output ready);
endinterface

### hdl/dual_window_sound_onset_detector.sv
// Throughput: one item per cycle; input ready depends only on the pipeline stages being free.
// Stages: input register, window update register, result register.
// Reset: the sample window clears to zeros, both sums to zero, light_threshold to 0
// (no onset until a threshold is written); no reset pass, items are taken at once.
module dual_window_sound_onset_detector
  import dwso_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  dwso_in_if.sink    in_i,
  dwso_out_if.source out_o,
  dwso_cfg_if.sink   cfg_i
);

  light_t    thresh_q;
  logic      v1_q, v2_q, v3_q;
  sample_t   sample1_q;
  light_t    light1_q;
  logic      dark2_q;
  logic      onset3_q;
  logic      rdy1, rdy2, rdy3;
  logic      adv12, adv23;
  win_sums_t sums;
  logic      hit;

  // Configuration register, always ready
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= '0;
    end else if (cfg_i.valid) begin
      thresh_q <= cfg_i.light_threshold;
    end
  end

  // Stage readiness: a stage takes a new item when empty or when it drains
  assign rdy3  = !v3_q || out_o.ready;
  assign rdy2  = !v2_q || rdy3;
  assign rdy1  = !v1_q || rdy2;
  assign adv12 = v1_q && rdy2;
  assign adv23 = v2_q && rdy3;

  assign in_i.ready = rdy1;

  // Stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= in_i.valid;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
    end
  end

  // Hold the input transfer
  always_ff @(posedge clk_i) begin
    if (in_i.valid && rdy1) begin
      sample1_q <= in_i.sample;
      light1_q  <= in_i.light_level;
    end
  end

  // Capture the light test alongside the window update
  always_ff @(posedge clk_i) begin
    if (adv12) begin
      dark2_q <= (light1_q < thresh_q);
    end
  end

  dwso_window u_window (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv12),
    .sample_i (sample1_q),
    .sums_o   (sums)
  );

  dwso_decide u_decide (
    .sums_i  (sums),
    .dark_i  (dark2_q),
    .onset_o (hit)
  );

  // Result register
  always_ff @(posedge clk_i) begin
    if (adv23) begin
      onset3_q <= hit;
    end
  end

  assign out_o.valid = v3_q;
  assign out_o.onset = onset3_q;

endmodule

### hdl/dwso_window.sv
module dwso_window
  import dwso_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      adv_i,
  input  sample_t   sample_i,
  output win_sums_t sums_o
);

  sample_t taps_q [TOTAL_LEN];
  recent_t recent_q, recent_d;
  older_t  older_q, older_d;
  sample_t handed;
  sample_t oldest;

  // The sample leaving the short window and the one dropping off the long window
  assign handed = taps_q[SHORT_LEN-1];
  assign oldest = taps_q[TOTAL_LEN-1];

  // Move the handed sample from the short sum to the long sum, drop the oldest
  assign recent_d = recent_q + RECENT_W'(sample_i) - RECENT_W'(handed);
  assign older_d  = older_q + OLDER_W'(handed) - OLDER_W'(oldest);

  // Shift line of past samples, cleared to zeros on reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TOTAL_LEN; i++) begin
        taps_q[i] <= '0;
      end
      recent_q <= '0;
      older_q  <= '0;
    end else if (adv_i) begin
      taps_q[0] <= sample_i;
      for (int i = 1; i < TOTAL_LEN; i++) begin
        taps_q[i] <= taps_q[i-1];
      end
      recent_q <= recent_d;
      older_q  <= older_d;
    end
  end

  assign sums_o.recent = recent_q;
  assign sums_o.older  = older_q;

endmodule

### hdl/dwso_decide.sv
module dwso_decide
  import dwso_pkg::*;
(
  input  win_sums_t sums_i,
  input  logic      dark_i,
  output logic      onset_o
);

  prod_t lhs;
  prod_t rhs;

  // Compare scaled means without division
  assign lhs = PROD_W'(sums_i.recent) * PROD_W'(LHS_K);
  assign rhs = PROD_W'(sums_i.older) * PROD_W'(RHS_K);

  assign onset_o = (lhs > rhs) && dark_i;

endmodule

### hdl/dwso_checker.sv
module dwso_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic onset
);

  // A result offered but not taken stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn before transfer");

  // A stalled result keeps its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> $stable(onset))
    else $error("stalled result changed");

  // A draining output never blocks the input side
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready |-> in_ready)
    else $error("input stalled while output drains");

  // With the output taking results meanwhile, an accepted item comes out as an offered result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid && in_ready) ##1 out_ready ##1 out_ready |=> out_valid)
    else $error("result missing after free-flowing pipeline");

endmodule

bind dual_window_sound_onset_detector dwso_checker u_dwso_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (in_i.valid),
  .in_ready  (in_i.ready),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .onset     (out_o.onset)
);

### test/tb_top.sv
module tb_top;
  import dwso_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int LONG_HOLD   = 300;
  localparam int HOLD_AT     = 200;
  localparam int LIGHT_MAX   = (2 ** LIGHT_W) - 1;

  typedef struct {
    sample_t sample;
    light_t  light;
  } sound_item_t;

  logic clk_i;
  logic rst_ni;

  dwso_in_if  in_bus ();
  dwso_out_if out_bus ();
  dwso_cfg_if cfg_bus ();

  dual_window_sound_onset_detector dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus),
    .cfg_i  (cfg_bus)
  );

  // Predictor state: sample ring, write slot, window sums and threshold copy
  sample_t     ring_q [TOTAL_LEN];
  int unsigned slot_q;
  recent_t     recent_q;
  older_t      older_q;
  light_t      threshold_q;

  sound_item_t pending_items [$];
  logic        onset_due [$];
  sound_item_t next_item;

  int  errors;
  int  sent_count;
  int  src_gap;
  int  sink_gap;
  int  hold_left;
  bit  hold_done;
  bit  idle_en;
  int  cycles;

  // Slide both windows by one sample and decide the onset flag
  function automatic logic advance_window(sample_t x, light_t light);
    int unsigned mid;
    sample_t     handed;
    sample_t     dropped;
    logic [63:0] short_side;
    logic [63:0] long_side;
    mid = (slot_q + TOTAL_LEN - SHORT_LEN) % TOTAL_LEN;
    handed = ring_q[mid];
    dropped = ring_q[slot_q];
    recent_q = recent_q + x - handed;
    older_q = older_q + handed - dropped;
    ring_q[slot_q] = x;
    slot_q = (slot_q + 1) % TOTAL_LEN;
    short_side = 64'(recent_q) * 200 * LONG_LEN;
    long_side = 64'(older_q) * 201 * SHORT_LEN;
    return (short_side > long_side) && (light < threshold_q);
  endfunction

  // Clock
  always #5 clk_i = ~clk_i;

  // Run limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Sample driver: offer queued items, record expectations on each transfer
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_bus.valid <= 1'b0;
      in_bus.sample <= '0;
      in_bus.light_level <= '0;
      src_gap = 0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        onset_due.push_back(advance_window(in_bus.sample, in_bus.light_level));
        sent_count <= sent_count + 1;
      end
      if (!in_bus.valid || in_bus.ready) begin
        if (src_gap > 0) begin
          src_gap--;
          in_bus.valid <= 1'b0;
        end else if (idle_en && pending_items.size() > 0 && $urandom_range(0, 5) == 0) begin
          src_gap = $urandom_range(0, 10);
          in_bus.valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          next_item = pending_items.pop_front();
          in_bus.valid <= 1'b1;
          in_bus.sample <= next_item.sample;
          in_bus.light_level <= next_item.light;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compare each transfer with the oldest expectation
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
      sink_gap = 0;
      hold_left = 0;
      hold_done = 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (onset_due.size() == 0) begin
          $display("%0t: unexpected result, expected none, got onset %0b",
                   $time, out_bus.onset);
          errors++;
        end else if (onset_due[0] !== out_bus.onset) begin
          $display("%0t: onset mismatch, expected %0b, got %0b",
                   $time, onset_due[0], out_bus.onset);
          errors++;
          void'(onset_due.pop_front());
        end else begin
          void'(onset_due.pop_front());
        end
      end
      // Hold off once for a long stretch so that the pipeline backs up
      if (!hold_done && sent_count >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD;
        out_bus.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else if (sink_gap > 0) begin
        sink_gap--;
        out_bus.ready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        sink_gap = $urandom_range(0, 10);
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  task automatic write_light_threshold(light_t value);
    @(posedge clk_i);
    cfg_bus.valid <= 1'b1;
    cfg_bus.light_threshold <= value;
    do @(posedge clk_i); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    threshold_q = value;
  endtask

  // Wait until every item has been taken and every result has come back;
  // look between edges so that the driver's updates have settled
  task automatic drain_pipeline();
    while (pending_items.size() != 0 || in_bus.valid || onset_due.size() != 0)
      @(negedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic push_item(int sample, int light);
    sound_item_t item;
    if (sample < 0) sample = 0;
    if (sample > SAMPLE_MAX) sample = SAMPLE_MAX;
    item.sample = sample_t'(sample);
    item.light = light_t'(light);
    pending_items.push_back(item);
  endtask

  // Mostly below the threshold so that onsets can show, sometimes around or above it
  function automatic int pick_light();
    int r;
    int thr;
    r = $urandom_range(0, 9);
    thr = threshold_q;
    if (r < 6) return (thr == 0) ? 0 : $urandom_range(0, thr - 1);
    if (r == 6) begin
      r = thr + $urandom_range(0, 2) - 1;
      if (r < 0) r = 0;
      if (r > LIGHT_MAX) r = LIGHT_MAX;
      return r;
    end
    if (r < 9) return $urandom_range(0, LIGHT_MAX);
    return ($urandom_range(0, 1) == 1) ? LIGHT_MAX : 0;
  endfunction

  function automatic int pick_level();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return $urandom_range(0, SAMPLE_MAX);
    if (r < 8) return $urandom_range(0, 300);
    return $urandom_range(16000, SAMPLE_MAX);
  endfunction

  // Steady levels with small jitter followed by small steps, ramps, and plain noise
  task automatic queue_sound(int count);
    int left;
    int shape;
    int base;
    int jitter;
    int run;
    int step;
    int k;
    left = count;
    while (left > 0) begin
      shape = $urandom_range(0, 9);
      if (shape < 6) begin
        base = pick_level();
        jitter = $urandom_range(0, base / 60 + 1);
        run = $urandom_range(20, 140);
        for (k = 0; k < run && left > 0; k++) begin
          push_item(base + $urandom_range(0, 2 * jitter) - jitter, pick_light());
          left--;
        end
        // step the level by up to four percent, mostly upward
        step = base * $urandom_range(0, 40) / 1000 + $urandom_range(0, 3);
        base = ($urandom_range(0, 3) != 0) ? base + step : base - step;
        run = $urandom_range(4, 30);
        for (k = 0; k < run && left > 0; k++) begin
          push_item(base + $urandom_range(0, 2 * jitter) - jitter, pick_light());
          left--;
        end
      end else if (shape < 8) begin
        base = $urandom_range(0, 4000);
        step = $urandom_range(1, 120);
        run = $urandom_range(20, 100);
        for (k = 0; k < run && left > 0; k++) begin
          push_item(base + k * step, pick_light());
          left--;
        end
      end else begin
        run = $urandom_range(5, 30);
        for (k = 0; k < run && left > 0; k++) begin
          push_item($urandom_range(0, SAMPLE_MAX), pick_light());
          left--;
        end
      end
    end
  endtask

  initial begin
    int k;
    clk_i = 1'b0;
    rst_ni = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.sample = '0;
    in_bus.light_level = '0;
    out_bus.ready = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.light_threshold = '0;
    for (k = 0; k < TOTAL_LEN; k++) ring_q[k] = '0;
    slot_q = 0;
    recent_q = '0;
    older_q = '0;
    threshold_q = '0;
    errors = 0;
    sent_count = 0;
    cycles = 0;
    idle_en = 1'b1;

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Threshold at all ones: every light level but the top one lets onsets through
    write_light_threshold(light_t'(LIGHT_MAX));
    push_item(0, 0);                 // all zeros: equal means, no onset
    push_item(SAMPLE_MAX, 0);        // warm-up against a window of zeros
    push_item(SAMPLE_MAX, LIGHT_MAX - 1);
    push_item(SAMPLE_MAX, LIGHT_MAX);  // light equal to threshold
    push_item(0, 1);
    for (k = 0; k < 12; k++) push_item(SAMPLE_MAX, $urandom_range(0, LIGHT_MAX));
    push_item(0, 0);
    push_item(1, 0);
    push_item(SAMPLE_MAX - 1, 65536);
    queue_sound(380);
    drain_pipeline();

    // Threshold zero: never an onset
    write_light_threshold('0);
    push_item(SAMPLE_MAX, 0);
    push_item(SAMPLE_MAX, 0);
    queue_sound(150);
    drain_pipeline();

    // Threshold at 83886, with light levels just below, at and above it
    write_light_threshold(light_t'(83886));
    push_item(SAMPLE_MAX, 83885);
    push_item(SAMPLE_MAX, 83886);
    push_item(SAMPLE_MAX, 83887);
    queue_sound(400);
    drain_pipeline();

    write_light_threshold(light_t'($urandom_range(1, LIGHT_MAX)));
    queue_sound(250);
    drain_pipeline();

    // Only darkness counts; no idling on either side from here on
    idle_en = 1'b0;
    write_light_threshold(light_t'(1));
    queue_sound(200);
    drain_pipeline();

    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/dwso_pkg.sv
hdl/dwso_ifs.sv
hdl/dwso_window.sv
hdl/dwso_decide.sv
hdl/dual_window_sound_onset_detector.sv
hdl/dwso_checker.sv
test/tb_top.sv
